// ===== hw/rtl/earliest_free_server_assigner_core_macros.svh =====
// assertion macros for the earliest free server assigner
`ifndef EARLIEST_FREE_SERVER_ASSIGNER_CORE_MACROS_SVH
`define EARLIEST_FREE_SERVER_ASSIGNER_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// checked only while out of reset
`define EFSA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked at every edge, reset included
`define EFSA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define EFSA_ASSERT(lbl, prop, msg)
`define EFSA_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== hw/rtl/efsa_pkg.sv =====
// shared constants, types and controller encodings for the server assigner
package efsa_pkg;

  localparam int MAX_SERVERS_DEF = 64;
  localparam int CFG_W           = 7;
  localparam int DUR_W           = 16;
  localparam int TIME_W          = 32;
  localparam int OUT_W           = 7;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_UPDATE = 5'b00100,
    ST_RSCAN  = 5'b01000,
    ST_REPORT = 5'b10000
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic scan_start;
    logic write;
    logic report;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
    logic last;
  } sts_t;

endpackage

// ===== hw/rtl/earliest_free_server_assigner_core.sv =====
// top level of the earliest free server assigner
// Items are taken one at a time while busy is low. An item carrying a job, an empty item
// ending a run, and a job item that also ends the run hold busy through their scans and
// the update or report that follows; an empty item that does not end a run is absorbed
// in its accept cycle. The finish time memory has a single read port, scanned one server
// per cycle by one comparator, once to place the job and once more for the end-of-run
// report. The result appears on the out_ ports for exactly one cycle with out_valid high,
// in the first cycle after busy falls, and must be taken then: the receiver cannot stall
// it. The table is cleared at the edge that raises out_valid, so no clearing pass follows
// reset or a run.
`include "earliest_free_server_assigner_core_macros.svh"

module earliest_free_server_assigner_core #(
  parameter int MAX_SERVERS = efsa_pkg::MAX_SERVERS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic                       in_has_job,
  input  logic [efsa_pkg::DUR_W-1:0] in_duration,
  input  logic                       in_last,
  input  logic                       cfg_we,
  input  logic [efsa_pkg::CFG_W-1:0] cfg_wdata,
  output logic                       out_valid,
  output logic [efsa_pkg::OUT_W-1:0] out_next_server,
  output logic                       out_saturated
);

  efsa_pkg::cmd_t cmd;
  efsa_pkg::sts_t sts;

  efsa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_has_job (in_has_job),
    .in_last    (in_last),
    .sts        (sts),
    .busy       (busy),
    .cmd        (cmd)
  );

  efsa_dp #(
    .MAX_SERVERS (MAX_SERVERS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_duration     (in_duration),
    .in_last         (in_last),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .out_valid       (out_valid),
    .out_next_server (out_next_server),
    .out_saturated   (out_saturated)
  );

  // a report only follows work in progress
  `EFSA_ASSERT(a_out_after_busy, out_valid |-> $past(busy), "result without a run in progress")
  // one result per run end
  `EFSA_ASSERT(a_out_single, out_valid |=> !out_valid, "result strobe held for two cycles")
  // an item that does work must raise busy
  `EFSA_ASSERT(a_busy_on_work, (start && !busy && (in_has_job || in_last)) |=> busy,
               "working item did not raise busy")
  // no result straight out of reset
  `EFSA_ASSERT_ALWAYS(a_quiet_reset, !rst_n |=> !out_valid, "result strobe after reset")

endmodule

// ===== hw/rtl/efsa_ctrl.sv =====
// sequencing state machine for the server assigner
module efsa_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic           in_has_job,
  input  logic           in_last,
  input  efsa_pkg::sts_t sts,
  output logic           busy,
  output efsa_pkg::cmd_t cmd
);

  efsa_pkg::state_t state_r, state_nxt;
  logic             accept;

  assign busy   = (state_r != efsa_pkg::ST_IDLE);
  assign accept = start && !busy;

  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    cmd.capture    = accept;
    unique case (state_r)
      efsa_pkg::ST_IDLE: begin
        if (accept && in_has_job) begin
          cmd.scan_start = 1'b1;
          state_nxt      = efsa_pkg::ST_SCAN;
        end else if (accept && in_last) begin
          cmd.scan_start = 1'b1;
          state_nxt      = efsa_pkg::ST_RSCAN;
        end
      end
      efsa_pkg::ST_SCAN: begin
        if (sts.scan_done) begin
          state_nxt = efsa_pkg::ST_UPDATE;
        end
      end
      efsa_pkg::ST_UPDATE: begin
        cmd.write = 1'b1;
        // the report scan may start now: its first read lands after the write
        if (sts.last) begin
          cmd.scan_start = 1'b1;
          state_nxt      = efsa_pkg::ST_RSCAN;
        end else begin
          state_nxt = efsa_pkg::ST_IDLE;
        end
      end
      efsa_pkg::ST_RSCAN: begin
        if (sts.scan_done) begin
          state_nxt = efsa_pkg::ST_REPORT;
        end
      end
      efsa_pkg::ST_REPORT: begin
        cmd.report = 1'b1;
        state_nxt  = efsa_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = efsa_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= efsa_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hw/rtl/efsa_dp.sv =====
// finish time memory, scanning comparator, saturating adder and result registers
module efsa_dp #(
  parameter int MAX_SERVERS = efsa_pkg::MAX_SERVERS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  efsa_pkg::cmd_t             cmd,
  output efsa_pkg::sts_t             sts,
  input  logic [efsa_pkg::DUR_W-1:0] in_duration,
  input  logic                       in_last,
  input  logic                       cfg_we,
  input  logic [efsa_pkg::CFG_W-1:0] cfg_wdata,
  output logic                       out_valid,
  output logic [efsa_pkg::OUT_W-1:0] out_next_server,
  output logic                       out_saturated
);

  localparam int IDX_W  = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
  localparam int TIME_W = efsa_pkg::TIME_W;

  // finish time store and its per-entry valid bits
  logic [TIME_W-1:0]      ft_mem [MAX_SERVERS];
  logic [MAX_SERVERS-1:0] vld_r, vld_nxt;
  logic [TIME_W-1:0]      rd_data_r;
  logic                   vld_q_r;

  logic [IDX_W-1:0] last_idx_r, last_idx_nxt, cfg_last_idx;
  logic [efsa_pkg::DUR_W-1:0] dur_r, dur_nxt;
  logic             last_r, last_nxt;
  logic             sat_r, sat_nxt;

  logic             issuing_r, issuing_nxt;
  logic [IDX_W-1:0] rd_idx_r, rd_idx_nxt;
  logic             cmp_en_r, cmp_en_nxt;
  logic [IDX_W-1:0] cmp_idx_r, cmp_idx_nxt;
  logic [TIME_W-1:0] best_val_r, best_val_nxt;
  logic [IDX_W-1:0] best_idx_r, best_idx_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic [efsa_pkg::OUT_W-1:0] out_next_server_r, out_next_server_nxt;
  logic                       out_saturated_r, out_saturated_nxt;

  logic [TIME_W-1:0] rd_val;
  logic              take;
  logic [TIME_W:0]   sum;
  logic [TIME_W-1:0] upd_val;
  logic [IDX_W:0]    idx_p1;

  // clamp the written server count to 1..MAX_SERVERS, kept as the last index
  always_comb begin
    if (cfg_wdata == '0 || MAX_SERVERS == 1) begin
      cfg_last_idx = '0;
    end else if (32'(cfg_wdata) > 32'(MAX_SERVERS)) begin
      cfg_last_idx = IDX_W'(MAX_SERVERS - 1);
    end else begin
      cfg_last_idx = IDX_W'(cfg_wdata - 1'b1);
    end
  end

  assign rd_val  = vld_q_r ? rd_data_r : '0;
  assign take    = cmp_en_r && ((cmp_idx_r == '0) || (rd_val < best_val_r));
  assign sum     = {1'b0, best_val_r} + (TIME_W + 1)'(dur_r);
  assign upd_val = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
  assign idx_p1  = {1'b0, best_idx_r} + (IDX_W + 1)'(1);

  assign sts.scan_done = cmp_en_r && (cmp_idx_r == last_idx_r);
  assign sts.last      = last_r;

  always_comb begin
    last_idx_nxt        = cfg_we ? cfg_last_idx : last_idx_r;
    dur_nxt             = cmd.capture ? in_duration : dur_r;
    last_nxt            = cmd.capture ? in_last : last_r;
    vld_nxt             = vld_r;
    sat_nxt             = sat_r;
    issuing_nxt         = issuing_r;
    rd_idx_nxt          = rd_idx_r;
    cmp_en_nxt          = issuing_r;
    cmp_idx_nxt         = rd_idx_r;
    best_val_nxt        = take ? rd_val : best_val_r;
    best_idx_nxt        = take ? cmp_idx_r : best_idx_r;
    out_valid_nxt       = cmd.report;
    out_next_server_nxt = out_next_server_r;
    out_saturated_nxt   = out_saturated_r;

    // one entry read per cycle until the last active server
    if (cmd.scan_start) begin
      issuing_nxt = 1'b1;
      rd_idx_nxt  = '0;
    end else if (issuing_r) begin
      if (rd_idx_r == last_idx_r) begin
        issuing_nxt = 1'b0;
      end else begin
        rd_idx_nxt = rd_idx_r + 1'b1;
      end
    end

    if (cmd.write) begin
      vld_nxt[best_idx_r] = 1'b1;
      if (sum[TIME_W]) begin
        sat_nxt = 1'b1;
      end
    end

    // report, then wipe the table for the next run
    if (cmd.report) begin
      out_next_server_nxt = efsa_pkg::OUT_W'(idx_p1);
      out_saturated_nxt   = sat_r;
      vld_nxt             = '0;
      sat_nxt             = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write) begin
      ft_mem[best_idx_r] <= upd_val;
    end
    rd_data_r <= ft_mem[rd_idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      sat_r       <= 1'b0;
      last_idx_r  <= '0;
      last_r      <= 1'b0;
      issuing_r   <= 1'b0;
      cmp_en_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r       <= vld_nxt;
      sat_r       <= sat_nxt;
      last_idx_r  <= last_idx_nxt;
      last_r      <= last_nxt;
      issuing_r   <= issuing_nxt;
      cmp_en_r    <= cmp_en_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    vld_q_r           <= vld_r[rd_idx_r];
    dur_r             <= dur_nxt;
    rd_idx_r          <= rd_idx_nxt;
    cmp_idx_r         <= cmp_idx_nxt;
    best_val_r        <= best_val_nxt;
    best_idx_r        <= best_idx_nxt;
    out_next_server_r <= out_next_server_nxt;
    out_saturated_r   <= out_saturated_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_next_server = out_next_server_r;
  assign out_saturated   = out_saturated_r;

endmodule

// ===== tb/sv/tb.sv =====
// self-checking testbench for the earliest free server assigner core
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import efsa_pkg::*;

  localparam int SERVERS      = MAX_SERVERS_DEF;
  localparam int SETTLE_CYCLS = 2 * SERVERS + 8;
  localparam int RANDOM_ITEMS = 1800;
  localparam int MAX_GAP      = 80;
  localparam logic [7:0] KEEP = 8'hFF;

  typedef struct packed {
    logic [OUT_W-1:0] server;
    logic             sat;
  } report_t;

  typedef struct packed {
    logic [7:0]       cfg;
    logic             has_job;
    logic [DUR_W-1:0] dur;
    logic             last;
    int               reps;
    logic             typed;
    logic [OUT_W-1:0] srv;
    logic             sat;
  } row_t;

  localparam int NROWS = 21;
  localparam row_t SCRIPT [NROWS] = '{
    '{KEEP,  1'b0, 16'h0000, 1'b1, 1,     1'b1, 7'd1,  1'b0}, // empty run straight after reset
    '{8'd0,  1'b1, 16'hFFFF, 1'b1, 1,     1'b1, 7'd1,  1'b0}, // zero count acts as one server
    '{8'd4,  1'b1, 16'h0000, 1'b1, 1,     1'b1, 7'd1,  1'b0},
    '{KEEP,  1'b1, 16'd7,    1'b0, 1,     1'b0, 7'd0,  1'b0},
    '{KEEP,  1'b1, 16'd3,    1'b0, 1,     1'b0, 7'd0,  1'b0},
    '{KEEP,  1'b0, 16'hFFFF, 1'b0, 1,     1'b0, 7'd0,  1'b0}, // ignored item inside a run
    '{KEEP,  1'b1, 16'd3,    1'b0, 1,     1'b0, 7'd0,  1'b0}, // tie goes to the lower server
    '{KEEP,  1'b1, 16'd9,    1'b0, 1,     1'b0, 7'd0,  1'b0},
    '{KEEP,  1'b0, 16'hFFFF, 1'b1, 1,     1'b0, 7'd0,  1'b0},
    '{8'd64, 1'b1, 16'd1,    1'b0, 63,    1'b0, 7'd0,  1'b0},
    '{KEEP,  1'b0, 16'h0000, 1'b1, 1,     1'b1, 7'd64, 1'b0},
    '{8'd127,1'b1, 16'd5,    1'b0, 63,    1'b0, 7'd0,  1'b0}, // count above range clips
    '{KEEP,  1'b1, 16'h0000, 1'b1, 1,     1'b0, 7'd0,  1'b0},
    '{8'd4,  1'b1, 16'd10,   1'b0, 1,     1'b0, 7'd0,  1'b0},
    '{KEEP,  1'b1, 16'd20,   1'b0, 1,     1'b0, 7'd0,  1'b0},
    '{KEEP,  1'b1, 16'd30,   1'b0, 1,     1'b0, 7'd0,  1'b0},
    '{KEEP,  1'b1, 16'd40,   1'b0, 1,     1'b0, 7'd0,  1'b0},
    '{8'd2,  1'b1, 16'd5,    1'b0, 1,     1'b0, 7'd0,  1'b0}, // count shrinks mid run
    '{KEEP,  1'b1, 16'd10,   1'b0, 1,     1'b0, 7'd0,  1'b0},
    '{8'd4,  1'b0, 16'h0000, 1'b1, 1,     1'b0, 7'd0,  1'b0}, // and grows back for the report
    '{8'd100,1'b0, 16'h0000, 1'b1, 1,     1'b1, 7'd1,  1'b0}  // clipped count on an empty run
  };

  logic             clk = 1'b0;
  logic             rst_n;
  logic             start;
  logic             busy;
  logic             in_has_job;
  logic [DUR_W-1:0] in_duration;
  logic             in_last;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;
  logic             out_valid;
  logic [OUT_W-1:0] out_next_server;
  logic             out_saturated;

  // predictor state
  logic [TIME_W-1:0] free_at [SERVERS];
  logic              run_saturated;
  logic [CFG_W-1:0]  server_setting;

  report_t pending_reports [$];
  int      err_count;
  int      burst_left;

  earliest_free_server_assigner_core DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_has_job      (in_has_job),
    .in_duration     (in_duration),
    .in_last         (in_last),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .out_valid       (out_valid),
    .out_next_server (out_next_server),
    .out_saturated   (out_saturated)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int unsigned servers_in_use();
    int unsigned n;
    n = server_setting;
    if (n == 0) n = 1;
    if (n > SERVERS) n = SERVERS;
    return n;
  endfunction

  function automatic int unsigned earliest_free();
    int unsigned best;
    best = 0;
    for (int unsigned i = 1; i < servers_in_use(); i++) begin
      if (free_at[i] < free_at[best]) best = i;
    end
    return best;
  endfunction

  function automatic bit place_job(input logic has_job, input logic [DUR_W-1:0] dur,
                                   input logic last, output report_t rep);
    int unsigned       s;
    logic [TIME_W:0]   sum;
    rep = '0;
    if (has_job) begin
      s = earliest_free();
      sum = {1'b0, free_at[s]} + dur;
      if (sum[TIME_W]) begin
        free_at[s] = '1;
        run_saturated = 1'b1;
      end else begin
        free_at[s] = sum[TIME_W-1:0];
      end
    end
    if (!last) return 1'b0;
    rep.server = OUT_W'(earliest_free() + 1);
    rep.sat = run_saturated;
    for (int i = 0; i < SERVERS; i++) free_at[i] = '0;
    run_saturated = 1'b0;
    return 1'b1;
  endfunction

  task automatic send_item(input logic has_job, input logic [DUR_W-1:0] dur, input logic last,
                           input logic typed, input report_t typed_rep);
    report_t rep;
    @(negedge clk);
    start = 1'b1;
    in_has_job = has_job;
    in_duration = dur;
    in_last = last;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (place_job(has_job, dur, last, rep)) pending_reports.push_back(typed ? typed_rep : rep);
  endtask

  // bursts of back-to-back items with random holes between them
  task automatic pace(input int gap_cap);
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      case ($urandom_range(0, 9))
        0:       gap = $urandom_range(21, MAX_GAP);
        1, 2, 3: gap = $urandom_range(4, 20);
        default: gap = $urandom_range(1, 3);
      endcase
      if (gap > gap_cap) gap = gap_cap;
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(0, 30);
      repeat (gap) begin
        @(negedge clk);
        start = 1'b0;
      end
    end
  endtask

  // hold off until every report is in and the block has finished any job in flight
  task automatic settle();
    @(negedge clk);
    start = 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLS) @(posedge clk);
  endtask

  task automatic write_servers(input logic [CFG_W-1:0] val);
    settle();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = val;
    @(posedge clk);
    server_setting = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic logic [CFG_W-1:0] pick_count();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return CFG_W'(SERVERS);
      2:       return CFG_W'($urandom_range(SERVERS + 1, 127));
      3, 4, 5: return CFG_W'($urandom_range(9, SERVERS - 1));
      default: return CFG_W'($urandom_range(1, 8));
    endcase
  endfunction

  function automatic logic [DUR_W-1:0] pick_duration();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return DUR_W'($urandom_range(0, 3));
      default: return DUR_W'($urandom);
    endcase
  endfunction

  always @(posedge clk) begin
    report_t exp_rep;
    if (rst_n && out_valid) begin
      if (pending_reports.size() == 0) begin
        err_count++;
        $display("%0t: unexpected report, server %0d saturated %0b",
                 $time, out_next_server, out_saturated);
      end else begin
        exp_rep = pending_reports.pop_front();
        if (out_next_server !== exp_rep.server) begin
          err_count++;
          $display("%0t: next_server expected %0d got %0d",
                   $time, exp_rep.server, out_next_server);
        end
        if (out_saturated !== exp_rep.sat) begin
          err_count++;
          $display("%0t: saturated expected %0b got %0b", $time, exp_rep.sat, out_saturated);
        end
      end
    end
  end

  initial begin
    #15_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    int      counted;
    int      jobs;
    bit      end_on_job;
    report_t no_rep;
    rst_n = 1'b0;
    start = 1'b0;
    in_has_job = 1'b0;
    in_duration = '0;
    in_last = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    err_count = 0;
    burst_left = 0;
    counted = 0;
    no_rep = '0;
    for (int i = 0; i < SERVERS; i++) free_at[i] = '0;
    run_saturated = 1'b0;
    server_setting = CFG_W'(1);
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    for (int r = 0; r < NROWS; r++) begin
      if (SCRIPT[r].cfg != KEEP) write_servers(SCRIPT[r].cfg[CFG_W-1:0]);
      for (int k = 0; k < SCRIPT[r].reps; k++) begin
        send_item(SCRIPT[r].has_job, SCRIPT[r].dur, SCRIPT[r].last, SCRIPT[r].typed,
                  '{SCRIPT[r].srv, SCRIPT[r].sat});
        // long runs that fill all but one server go with only short holes
        pace(SCRIPT[r].reps > 1 ? 2 : MAX_GAP);
      end
    end

    while (counted < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) write_servers(pick_count());
      if ($urandom_range(0, 19) == 0) settle();
      jobs = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2) : $urandom_range(1, 12);
      end_on_job = (jobs > 0) && ($urandom_range(0, 1) == 1);
      for (int j = 0; j < jobs; j++) begin
        if ($urandom_range(0, 29) == 0) write_servers(pick_count());
        if ($urandom_range(0, 9) == 0) begin
          send_item(1'b0, DUR_W'($urandom), 1'b0, 1'b0, no_rep);
          pace(MAX_GAP);
        end
        send_item(1'b1, pick_duration(), end_on_job && (j == jobs - 1), 1'b0, no_rep);
        pace(MAX_GAP);
        counted++;
      end
      if (!end_on_job) begin
        send_item(1'b0, DUR_W'($urandom), 1'b1, 1'b0, no_rep);
        pace(MAX_GAP);
        counted++;
      end
    end

    settle();
    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/efsa_pkg.sv
hw/rtl/efsa_ctrl.sv
hw/rtl/efsa_dp.sv
hw/rtl/earliest_free_server_assigner_core.sv
tb/sv/tb.sv
